@@ hdl/iwt_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the
// inflight window tracker. No dependencies.
package iwt_pkg;

  // Slot store geometry
  localparam int unsigned WINDOW_MAX = 64;
  localparam int unsigned SLOT_W     = $clog2(WINDOW_MAX);
  localparam int unsigned SCAN_W     = $clog2(WINDOW_MAX + 1);
  // Slot word: {request id, sent tick}
  localparam int unsigned MEM_W      = 64;

  // Item types
  typedef logic [1:0] req_type_t;
  localparam req_type_t REQ_SEND  = 2'd0;
  localparam req_type_t REQ_REPLY = 2'd1;
  localparam req_type_t REQ_TICK  = 2'd2;

  // Result status codes
  typedef logic [2:0] status_t;
  localparam status_t ST_SENT      = 3'd0;
  localparam status_t ST_REFUSED   = 3'd1;
  localparam status_t ST_MATCHED   = 3'd2;
  localparam status_t ST_UNMATCHED = 3'd3;
  localparam status_t ST_TICK_DONE = 3'd4;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_WINDOW  = 2'd0;
  localparam cfg_index_t CFG_TIMEOUT = 2'd1;
  localparam cfg_index_t CFG_TOTAL   = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic              accept;
    logic              claim;
    logic              rd_en;
    logic [SLOT_W-1:0] idx;
    logic              eval;
    logic [SLOT_W-1:0] eval_idx;
  } iwt_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic send_ok;
    logic slot_free;
    logic hit;
  } iwt_stat_t;

endpackage

@@ hdl/inflight_window_tracker.sv @@
// Top level of the inflight window tracker: joins controller and datapath.
// Uses iwt_pkg, iwt_ctrl, iwt_datapath (and iwt_ram through it).
//
//  channel   handshake                 payload
//  -------   ------------------------  -----------------------------------------
//  item in   start & !busy             req_type_i, reply_id_i
//  result    result_valid_o (1 cycle)  status_o .. all_done_o
//  config    cfg_valid_i & cfg_ready_o cfg_index_i, cfg_data_i
//
// A send walks the valid bits one slot a cycle. For a reply or tick the slot
// RAM, which has one read port, is read one slot a cycle with a registered
// read; a reply stops at its match. An unused type or refused send goes from
// accept straight to the result. Reset is asynchronous and active low; no
// clearing pass is needed. The result receiver cannot stall.
module inflight_window_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] reply_id_i,
  output logic        result_valid_o,
  output logic [2:0]  status_o,
  output logic [31:0] req_id_o,
  output logic [15:0] rtt_ticks_o,
  output logic [6:0]  expired_now_o,
  output logic [6:0]  inflight_now_o,
  output logic [30:0] sent_total_o,
  output logic [30:0] received_total_o,
  output logic [30:0] lost_total_o,
  output logic [47:0] rtt_sum_o,
  output logic        all_done_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [30:0] cfg_data_i
);

  iwt_pkg::iwt_cmd_t  cmd;
  iwt_pkg::iwt_stat_t stat;

  iwt_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .req_type_i     (req_type_i),
    .stat_i         (stat),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  iwt_datapath u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i),
    .req_type_i       (req_type_i),
    .reply_id_i       (reply_id_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .status_o         (status_o),
    .req_id_o         (req_id_o),
    .rtt_ticks_o      (rtt_ticks_o),
    .expired_now_o    (expired_now_o),
    .inflight_now_o   (inflight_now_o),
    .sent_total_o     (sent_total_o),
    .received_total_o (received_total_o),
    .lost_total_o     (lost_total_o),
    .rtt_sum_o        (rtt_sum_o),
    .all_done_o       (all_done_o)
  );

endmodule

@@ hdl/iwt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iwt_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/iwt_datapath.sv @@
// Datapath of the inflight window tracker: config registers, slot valid
// bits, slot RAM, counters and result registers. Uses iwt_pkg and iwt_ram.
module iwt_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [1:0]          cfg_index_i,
  input  logic [30:0]         cfg_data_i,
  input  logic [1:0]          req_type_i,
  input  logic [31:0]         reply_id_i,
  input  iwt_pkg::iwt_cmd_t   cmd_i,
  output iwt_pkg::iwt_stat_t  stat_o,
  output logic [2:0]          status_o,
  output logic [31:0]         req_id_o,
  output logic [15:0]         rtt_ticks_o,
  output logic [6:0]          expired_now_o,
  output logic [6:0]          inflight_now_o,
  output logic [30:0]         sent_total_o,
  output logic [30:0]         received_total_o,
  output logic [30:0]         lost_total_o,
  output logic [47:0]         rtt_sum_o,
  output logic                all_done_o
);

  // Configuration
  logic [6:0]  win_q, win_d;
  logic [15:0] timeout_q, timeout_d;
  logic [30:0] total_q, total_d;
  // Tracker state
  logic [iwt_pkg::WINDOW_MAX-1:0] valid_q, valid_d;
  logic [31:0] tick_q, tick_d;
  logic [31:0] next_id_q, next_id_d;
  logic [6:0]  inflight_q, inflight_d;
  logic [30:0] sent_q, sent_d;
  logic [30:0] recv_q, recv_d;
  logic [30:0] lost_q, lost_d;
  logic [47:0] rtt_acc_q, rtt_acc_d;
  // Current item and its result
  logic [1:0]  type_q, type_d;
  logic [31:0] rid_q, rid_d;
  logic [2:0]  status_q, status_d;
  logic [31:0] req_out_q, req_out_d;
  logic [15:0] rtt_out_q, rtt_out_d;
  logic [6:0]  exp_q, exp_d;

  logic [iwt_pkg::MEM_W-1:0] rdata;
  logic [31:0] rd_id, rd_tick, age;
  logic [48:0] rtt_sum_ext;
  logic [31:0] done_sum;
  logic        hit;

  // Slot RAM: {id, sent tick} per slot
  iwt_ram #(
    .WIDTH (iwt_pkg::MEM_W),
    .DEPTH (iwt_pkg::WINDOW_MAX)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.claim),
    .waddr_i (cmd_i.idx),
    .wdata_i ({next_id_q, tick_q}),
    .re_i    (cmd_i.rd_en),
    .raddr_i (cmd_i.idx),
    .rdata_o (rdata)
  );

  assign rd_id       = rdata[63:32];
  assign rd_tick     = rdata[31:0];
  assign age         = tick_q - rd_tick;
  assign rtt_sum_ext = {1'b0, rtt_acc_q} + {17'd0, age};

  // Match test for the slot whose read data just returned
  assign hit = valid_q[cmd_i.eval_idx] &&
               ((type_q == iwt_pkg::REQ_REPLY) ? (rd_id == rid_q)
                                               : (age >= {16'd0, timeout_q}));

  // Refuse a send when every slot is taken, even if the window allows more
  assign stat_o.send_ok   = (next_id_q < {1'b0, total_q}) && (inflight_q < win_q) &&
                            (inflight_q < 7'(iwt_pkg::WINDOW_MAX));
  assign stat_o.slot_free = !valid_q[cmd_i.idx];
  assign stat_o.hit       = hit;

  // Next-state logic
  always_comb begin
    win_d      = win_q;
    timeout_d  = timeout_q;
    total_d    = total_q;
    valid_d    = valid_q;
    tick_d     = tick_q;
    next_id_d  = next_id_q;
    inflight_d = inflight_q;
    sent_d     = sent_q;
    recv_d     = recv_q;
    lost_d     = lost_q;
    rtt_acc_d  = rtt_acc_q;
    type_d     = type_q;
    rid_d      = rid_q;
    status_d   = status_q;
    req_out_d  = req_out_q;
    rtt_out_d  = rtt_out_q;
    exp_d      = exp_q;

    // Register writes
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        iwt_pkg::CFG_WINDOW:  win_d     = cfg_data_i[6:0];
        iwt_pkg::CFG_TIMEOUT: timeout_d = cfg_data_i[15:0];
        iwt_pkg::CFG_TOTAL:   total_d   = cfg_data_i;
        default: ;
      endcase
    end

    // Latch a new item and preset its result; a tick item also advances the tick
    if (cmd_i.accept) begin
      type_d    = req_type_i;
      rid_d     = reply_id_i;
      req_out_d = '0;
      rtt_out_d = '0;
      exp_d     = '0;
      case (req_type_i)
        iwt_pkg::REQ_SEND:  status_d = iwt_pkg::ST_REFUSED;
        iwt_pkg::REQ_REPLY: status_d = iwt_pkg::ST_UNMATCHED;
        iwt_pkg::REQ_TICK: begin
          status_d = iwt_pkg::ST_TICK_DONE;
          tick_d   = tick_q + 32'd1;
        end
        default: status_d = iwt_pkg::ST_TICK_DONE;
      endcase
    end

    // Take a free slot for a send
    if (cmd_i.claim) begin
      valid_d[cmd_i.idx] = 1'b1;
      inflight_d = inflight_q + 7'd1;
      sent_d     = sent_q + 31'd1;
      req_out_d  = next_id_q;
      next_id_d  = next_id_q + 32'd1;
      status_d   = iwt_pkg::ST_SENT;
    end

    // Free a matched or expired slot
    if (cmd_i.eval && hit) begin
      valid_d[cmd_i.eval_idx] = 1'b0;
      inflight_d = inflight_q - 7'd1;
      if (type_q == iwt_pkg::REQ_REPLY) begin
        recv_d    = recv_q + 31'd1;
        rtt_acc_d = rtt_sum_ext[48] ? '1 : rtt_sum_ext[47:0];
        rtt_out_d = (|age[31:16]) ? 16'hFFFF : age[15:0];
        req_out_d = rid_q;
        status_d  = iwt_pkg::ST_MATCHED;
      end else begin
        lost_d = lost_q + 31'd1;
        exp_d  = exp_q + 7'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= 7'd64;
      timeout_q  <= 16'd100;
      total_q    <= 31'd100000;
      valid_q    <= '0;
      tick_q     <= '0;
      next_id_q  <= '0;
      inflight_q <= '0;
      sent_q     <= '0;
      recv_q     <= '0;
      lost_q     <= '0;
      rtt_acc_q  <= '0;
    end else begin
      win_q      <= win_d;
      timeout_q  <= timeout_d;
      total_q    <= total_d;
      valid_q    <= valid_d;
      tick_q     <= tick_d;
      next_id_q  <= next_id_d;
      inflight_q <= inflight_d;
      sent_q     <= sent_d;
      recv_q     <= recv_d;
      lost_q     <= lost_d;
      rtt_acc_q  <= rtt_acc_d;
    end
  end

  // Item and result payload
  always_ff @(posedge clk_i) begin
    type_q    <= type_d;
    rid_q     <= rid_d;
    status_q  <= status_d;
    req_out_q <= req_out_d;
    rtt_out_q <= rtt_out_d;
    exp_q     <= exp_d;
  end

  assign done_sum = {1'b0, recv_q} + {1'b0, lost_q};

  assign cfg_ready_o      = 1'b1;
  assign status_o         = status_q;
  assign req_id_o         = req_out_q;
  assign rtt_ticks_o      = rtt_out_q;
  assign expired_now_o    = exp_q;
  assign inflight_now_o   = inflight_q;
  assign sent_total_o     = sent_q;
  assign received_total_o = recv_q;
  assign lost_total_o     = lost_q;
  assign rtt_sum_o        = rtt_acc_q;
  assign all_done_o       = done_sum >= {1'b0, total_q};

`ifndef ASSERT_OFF
  // Occupancy count tracks the valid bits
  a_count_matches_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_q) == int'(inflight_q))
    else $error("inflight count differs from number of valid slots");

  // A claim grows occupancy by exactly one
  a_claim_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.claim |=> inflight_q == $past(inflight_q) + 7'd1)
    else $error("claim did not add one in-flight request");
`endif

endmodule

@@ hdl/iwt_ctrl.sv @@
// Controller of the inflight window tracker: sequences accept, slot search,
// RAM scan and result strobe. Uses iwt_pkg.
module iwt_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  input  logic [1:0]          req_type_i,
  input  iwt_pkg::iwt_stat_t  stat_i,
  output iwt_pkg::iwt_cmd_t   cmd_o,
  output logic                busy,
  output logic                result_valid_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SEND = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0]                   state_q, state_d;
  logic [iwt_pkg::SCAN_W-1:0]   idx_q, idx_d;
  logic                         reply_q, reply_d;
  logic                         ev_vld_q, ev_vld_d;
  logic [iwt_pkg::SLOT_W-1:0]   ev_idx_q, ev_idx_d;
  logic                         ev_last_q, ev_last_d;
  logic                         issue;

  // Sequencing
  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    reply_d = reply_q;
    issue   = 1'b0;
    cmd_o          = '0;
    cmd_o.idx      = idx_q[iwt_pkg::SLOT_W-1:0];
    cmd_o.eval_idx = ev_idx_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.accept = 1'b1;
          idx_d   = '0;
          reply_d = (req_type_i == iwt_pkg::REQ_REPLY);
          case (req_type_i) inside
            iwt_pkg::REQ_SEND:                    state_d = stat_i.send_ok ? S_SEND : S_DONE;
            iwt_pkg::REQ_REPLY, iwt_pkg::REQ_TICK: state_d = S_SCAN;
            default:                              state_d = S_DONE;
          endcase
        end
      end
      S_SEND: begin
        // Walk valid bits up to the lowest free slot
        if (stat_i.slot_free) begin
          cmd_o.claim = 1'b1;
          state_d     = S_DONE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_SCAN: begin
        // Issue one RAM read per cycle, test its data in the cycle after
        issue       = (idx_q < iwt_pkg::SCAN_W'(iwt_pkg::WINDOW_MAX));
        cmd_o.rd_en = issue;
        if (issue) begin
          idx_d = idx_q + 1'b1;
        end
        if (ev_vld_q) begin
          cmd_o.eval = 1'b1;
          if ((reply_q && stat_i.hit) || ev_last_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase

    ev_vld_d  = issue;
    ev_idx_d  = idx_q[iwt_pkg::SLOT_W-1:0];
    ev_last_d = (idx_q == iwt_pkg::SCAN_W'(iwt_pkg::WINDOW_MAX - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      idx_q     <= '0;
      reply_q   <= 1'b0;
      ev_vld_q  <= 1'b0;
      ev_idx_q  <= '0;
      ev_last_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      reply_q   <= reply_d;
      ev_vld_q  <= ev_vld_d;
      ev_idx_q  <= ev_idx_d;
      ev_last_q <= ev_last_d;
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_DONE);

`ifndef ASSERT_OFF
  // Result strobe lasts a single cycle
  a_done_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o && !busy)
    else $error("result strobe held longer than one cycle");

  // A claim ends the send search with a result
  a_claim_then_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.claim |=> result_valid_o)
    else $error("claim not followed by result strobe");

  // Accepting an item makes the block busy
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> busy)
    else $error("accepted item did not raise busy");
`endif

endmodule

@@ dv/inflight_window_tracker_tb.sv @@
// Self-checking bench for inflight_window_tracker: directed cases, then random
// item streams checked against an in-bench model of the request slot window.
// Depends on iwt_pkg and the inflight_window_tracker RTL.
module inflight_window_tracker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam iwt_pkg::req_type_t REQ_UNUSED = 2'd3;
  localparam int unsigned SLOTS         = iwt_pkg::WINDOW_MAX;
  localparam int unsigned DRAIN_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 70;
  localparam int unsigned PRINT_LIMIT   = 40;
  localparam logic [30:0] TOTAL_MAX     = 31'h7FFF_FFFF;

  typedef struct {
    iwt_pkg::status_t status;
    logic [31:0] req_id;
    logic [15:0] rtt;
    logic [6:0]  expired;
    logic [6:0]  inflight;
    logic [30:0] sent;
    logic [30:0] received;
    logic [30:0] lost;
    logic [47:0] rtt_sum;
    logic        done;
  } outcome_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  iwt_pkg::req_type_t   req_type_i;
  logic [31:0]          reply_id_i;
  logic                 result_valid_o;
  iwt_pkg::status_t     status_o;
  logic [31:0]          req_id_o;
  logic [15:0]          rtt_ticks_o;
  logic [6:0]           expired_now_o;
  logic [6:0]           inflight_now_o;
  logic [30:0]          sent_total_o;
  logic [30:0]          received_total_o;
  logic [30:0]          lost_total_o;
  logic [47:0]          rtt_sum_o;
  logic                 all_done_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  iwt_pkg::cfg_index_t  cfg_index_i;
  logic [30:0]          cfg_data_i;

  // Shadow configuration and window state, at their reset values
  logic [6:0]  lim_window  = 7'd64;
  logic [15:0] lim_timeout = 16'd100;
  logic [30:0] lim_total   = 31'd100000;
  logic        slot_busy [SLOTS] = '{default: 1'b0};
  logic [31:0] slot_id   [SLOTS] = '{default: '0};
  logic [31:0] slot_tick [SLOTS] = '{default: '0};
  logic [31:0] tick_now  = '0;
  logic [31:0] next_id   = '0;
  logic [6:0]  inflight  = '0;
  logic [30:0] sent_cnt  = '0;
  logic [30:0] recv_cnt  = '0;
  logic [30:0] lost_tally = '0;
  logic [47:0] rtt_acc   = '0;

  outcome_t    pending_outcomes [$];
  int unsigned mismatches   = 0;
  int unsigned results_seen = 0;
  int unsigned items_by_type [4] = '{default: 0};
  int unsigned idle_pct     = 0;

  inflight_window_tracker u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .req_type_i       (req_type_i),
    .reply_id_i       (reply_id_i),
    .result_valid_o   (result_valid_o),
    .status_o         (status_o),
    .req_id_o         (req_id_o),
    .rtt_ticks_o      (rtt_ticks_o),
    .expired_now_o    (expired_now_o),
    .inflight_now_o   (inflight_now_o),
    .sent_total_o     (sent_total_o),
    .received_total_o (received_total_o),
    .lost_total_o     (lost_total_o),
    .rtt_sum_o        (rtt_sum_o),
    .all_done_o       (all_done_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin : watchdog
    #10ms;
    $display("Test completed with failures");
    $finish;
  end

  // Apply one item to the shadow window and return the result it must give
  function automatic outcome_t window_outcome(iwt_pkg::req_type_t kind, logic [31:0] rid);
    outcome_t    o;
    logic [31:0] age;
    int          free_idx;
    o = '{default: '0};
    o.status = iwt_pkg::ST_TICK_DONE;
    case (kind)
      iwt_pkg::REQ_SEND: begin
        o.status = iwt_pkg::ST_REFUSED;
        if (next_id < {1'b0, lim_total} && inflight < lim_window) begin
          free_idx = -1;
          for (int i = 0; i < SLOTS; i++)
            if (free_idx < 0 && !slot_busy[i]) free_idx = i;
          if (free_idx >= 0) begin
            slot_busy[free_idx] = 1'b1;
            slot_id[free_idx]   = next_id;
            slot_tick[free_idx] = tick_now;
            inflight     = inflight + 7'd1;
            sent_cnt     = sent_cnt + 31'd1;
            o.req_id     = next_id;
            next_id      = next_id + 32'd1;
            o.status     = iwt_pkg::ST_SENT;
          end
        end
      end
      iwt_pkg::REQ_REPLY: begin
        o.status = iwt_pkg::ST_UNMATCHED;
        // Free the lowest valid slot holding this id
        for (int i = 0; i < SLOTS; i++) begin
          if (o.status == iwt_pkg::ST_UNMATCHED && slot_busy[i] && slot_id[i] == rid) begin
            age          = tick_now - slot_tick[i];
            slot_busy[i] = 1'b0;
            inflight     = inflight - 7'd1;
            recv_cnt     = recv_cnt + 31'd1;
            if (48'hFFFF_FFFF_FFFF - rtt_acc < {16'd0, age}) rtt_acc = '1;
            else rtt_acc = rtt_acc + {16'd0, age};
            o.rtt        = (age > 32'h0000_FFFF) ? 16'hFFFF : age[15:0];
            o.req_id     = rid;
            o.status     = iwt_pkg::ST_MATCHED;
          end
        end
      end
      iwt_pkg::REQ_TICK: begin
        // Advance time, then drop every slot that has aged out
        tick_now = tick_now + 32'd1;
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_busy[i] && (tick_now - slot_tick[i]) >= {16'd0, lim_timeout}) begin
            slot_busy[i] = 1'b0;
            inflight     = inflight - 7'd1;
            lost_tally   = lost_tally + 31'd1;
            o.expired    = o.expired + 7'd1;
          end
        end
      end
      default: ;
    endcase
    o.inflight = inflight;
    o.sent     = sent_cnt;
    o.received = recv_cnt;
    o.lost     = lost_tally;
    o.rtt_sum  = rtt_acc;
    o.done     = ({1'b0, recv_cnt} + {1'b0, lost_tally}) >= {1'b0, lim_total};
    return o;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_LIMIT)
      $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
  endtask

  // Compare each result against the oldest expected outcome
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", status_o, 0);
      end else begin
        want = pending_outcomes.pop_front();
        results_seen++;
        if (status_o !== want.status) report_mismatch("status", status_o, want.status);
        if (req_id_o !== want.req_id)
          report_mismatch("req_id", req_id_o, want.req_id);
        if (rtt_ticks_o !== want.rtt) report_mismatch("rtt_ticks", rtt_ticks_o, want.rtt);
        if (expired_now_o !== want.expired)
          report_mismatch("expired_now", expired_now_o, want.expired);
        if (inflight_now_o !== want.inflight)
          report_mismatch("inflight_now", inflight_now_o, want.inflight);
        if (sent_total_o !== want.sent) report_mismatch("sent_total", sent_total_o, want.sent);
        if (received_total_o !== want.received)
          report_mismatch("received_total", received_total_o, want.received);
        if (lost_total_o !== want.lost) report_mismatch("lost_total", lost_total_o, want.lost);
        if (rtt_sum_o !== want.rtt_sum) report_mismatch("rtt_sum", rtt_sum_o, want.rtt_sum);
        if (all_done_o !== want.done) report_mismatch("all_done", all_done_o, want.done);
      end
    end
  end

  // Hold off for a random gap, then offer one item until the block takes it
  task automatic send_item(iwt_pkg::req_type_t kind, logic [31:0] rid);
    int unsigned gap;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct)
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 4);
    repeat (gap) begin
      @(negedge clk_i);
      start      <= 1'b0;
      req_type_i <= 2'($urandom);
      reply_id_i <= $urandom;
    end
    @(negedge clk_i);
    start      <= 1'b1;
    req_type_i <= kind;
    reply_id_i <= rid;
    do @(posedge clk_i); while (busy);
    pending_outcomes.push_back(window_outcome(kind, rid));
    items_by_type[kind]++;
  endtask

  // Stop offering items and wait for every outstanding result
  task automatic wait_drained();
    int unsigned waited;
    @(negedge clk_i);
    start  <= 1'b0;
    waited = 0;
    while (pending_outcomes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk_i);
      waited++;
    end
    if (pending_outcomes.size() != 0) begin
      report_mismatch("missing results", pending_outcomes.size(), 0);
      pending_outcomes.delete();
    end
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Write one register; call only with the block idle
  task automatic write_reg(iwt_pkg::cfg_index_t idx, logic [30:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      iwt_pkg::CFG_WINDOW:  lim_window  = value[6:0];
      iwt_pkg::CFG_TIMEOUT: lim_timeout = value[15:0];
      iwt_pkg::CFG_TOTAL:   lim_total   = value;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_send_and_reply();
    send_item(iwt_pkg::REQ_SEND, $urandom);
    send_item(iwt_pkg::REQ_REPLY, 32'd0);
    send_item(iwt_pkg::REQ_REPLY, 32'd0);
    send_item(iwt_pkg::REQ_REPLY, 32'hFFFF_FFFF);
    send_item(iwt_pkg::REQ_TICK, $urandom);
    send_item(REQ_UNUSED, $urandom);
  endtask

  task automatic test_window_limit();
    // One slot allowed: second send is refused
    wait_drained();
    write_reg(iwt_pkg::CFG_WINDOW, 31'd1);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    // Zero window refuses everything
    wait_drained();
    write_reg(iwt_pkg::CFG_WINDOW, 31'd0);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    wait_drained();
    write_reg(iwt_pkg::CFG_WINDOW, 31'd127);
  endtask

  task automatic test_timeout();
    // Outstanding request ages out after two ticks
    write_reg(iwt_pkg::CFG_TIMEOUT, 31'd2);
    send_item(iwt_pkg::REQ_TICK, $urandom);
    send_item(iwt_pkg::REQ_TICK, $urandom);
    // Zero timeout drops every slot at the next tick
    wait_drained();
    write_reg(iwt_pkg::CFG_TIMEOUT, 31'd0);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    send_item(iwt_pkg::REQ_TICK, $urandom);
    wait_drained();
    write_reg(iwt_pkg::CFG_TIMEOUT, 31'd65535);
  endtask

  task automatic test_round_trip();
    logic [31:0] id_out;
    id_out = next_id;
    send_item(iwt_pkg::REQ_SEND, $urandom);
    repeat (3) send_item(iwt_pkg::REQ_TICK, $urandom);
    send_item(iwt_pkg::REQ_REPLY, id_out);
  endtask

  task automatic test_total_limit();
    // Zero total refuses sends and reads as done
    wait_drained();
    write_reg(iwt_pkg::CFG_TOTAL, 31'd0);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    // Total lowered to the ids already issued
    wait_drained();
    write_reg(iwt_pkg::CFG_TOTAL, next_id[30:0]);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    // Room for exactly one more id
    wait_drained();
    write_reg(iwt_pkg::CFG_TOTAL, next_id[30:0] + 31'd1);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    wait_drained();
    write_reg(iwt_pkg::CFG_TOTAL, TOTAL_MAX);
    send_item(iwt_pkg::REQ_SEND, $urandom);
    send_item(iwt_pkg::REQ_REPLY, next_id - 32'd1);
  endtask

  // Mostly sends, replies to live ids and ticks; some stray replies and unused types
  task automatic run_random_phase(int unsigned count, logic [6:0] window,
                                  logic [15:0] timeout, logic [30:0] total,
                                  int unsigned idle);
    int unsigned        pick;
    int unsigned        sel;
    int unsigned        idx;
    iwt_pkg::req_type_t kind;
    logic [31:0]        rid;
    wait_drained();
    write_reg(iwt_pkg::CFG_WINDOW, {24'd0, window});
    write_reg(iwt_pkg::CFG_TIMEOUT, {15'd0, timeout});
    write_reg(iwt_pkg::CFG_TOTAL, total);
    idle_pct = idle;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      rid  = $urandom;
      if (pick < 42) begin
        kind = iwt_pkg::REQ_SEND;
      end else if (pick < 77) begin
        kind = iwt_pkg::REQ_REPLY;
        sel  = $urandom_range(0, 99);
        if (sel < 75 && inflight != 0) begin
          do idx = $urandom_range(0, SLOTS - 1); while (!slot_busy[idx]);
          rid = slot_id[idx];
        end else if (sel < 88) begin
          rid = next_id - 32'($urandom_range(0, 8));
        end
      end else if (pick < 97) begin
        kind = iwt_pkg::REQ_TICK;
      end else begin
        kind = REQ_UNUSED;
      end
      send_item(kind, rid);
      if ($urandom_range(0, 59) == 0) wait_drained();
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(200, 7'd64, 16'd30, TOTAL_MAX, 0);
    run_random_phase(200, 7'd4, 16'd8, TOTAL_MAX, 51);
    run_random_phase(200, 7'd127, 16'd65535, TOTAL_MAX, 31);
    run_random_phase(200, 7'd1, 16'd3, TOTAL_MAX, 51);
    run_random_phase(150, 7'd16, 16'd0, TOTAL_MAX, 0);
    run_random_phase(200, 7'd10, 16'd20, next_id[30:0] + 31'd60, 31);
    run_random_phase(250, 7'($urandom_range(1, 64)), 16'($urandom_range(1, 50)),
                     TOTAL_MAX, 51);
  endtask

  initial begin
    rst_ni      = 1'b0;
    start       = 1'b0;
    req_type_i  = iwt_pkg::REQ_SEND;
    reply_id_i  = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = iwt_pkg::CFG_WINDOW;
    cfg_data_i  = '0;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_send_and_reply();
    test_window_limit();
    test_timeout();
    test_round_trip();
    test_total_limit();
    test_random_traffic();
    wait_drained();

    $display("Ran %0d sends, %0d replies, %0d ticks, %0d unused-type items in 7 mixes;",
             items_by_type[iwt_pkg::REQ_SEND], items_by_type[iwt_pkg::REQ_REPLY],
             items_by_type[iwt_pkg::REQ_TICK], items_by_type[REQ_UNUSED]);
    $display("checked %0d results (%0d sent, %0d matched, %0d timed out), %0d mismatches.",
             results_seen, sent_cnt, recv_cnt, lost_tally, mismatches);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ inflight_window_tracker.f @@
hdl/iwt_pkg.sv
hdl/iwt_ram.sv
hdl/iwt_datapath.sv
hdl/iwt_ctrl.sv
hdl/inflight_window_tracker.sv
dv/inflight_window_tracker_tb.sv
